### src/assert_macros.svh
// assertion macros for the top-level rtl file of the calendar clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define RTCC_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rtcc assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define RTCC_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rtcc assertion failed");

`endif

### src/rtcc_pkg.sv
// types and constants of the calendar clock
package rtcc_pkg;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_SELECT = 2'd1,
        REQ_TOGGLE = 2'd2,
        REQ_SAMPLE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        FIELD_YEAR   = 3'd0,
        FIELD_MONTH  = 3'd1,
        FIELD_DAY    = 3'd2,
        FIELD_HOUR   = 3'd3,
        FIELD_MINUTE = 3'd4,
        FIELD_SECOND = 3'd5,
        FIELD_MILLI  = 3'd6
    } field_t;

    // packed so that year sits in the low bits, as on the result bus
    typedef struct packed {
        logic [2:0]  field;
        logic        running;
        logic [9:0]  milli;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } clk_state_t;

    localparam int STATE_W = $bits(clk_state_t);
    localparam int M_DATA_W = ((STATE_W + 7) / 8) * 8;

    localparam logic [13:0] YEAR_BASE = 14'd2026;
    localparam logic [13:0] YEAR_LAST = 14'd9999;
    localparam logic [9:0]  MILLI_LAST = 10'd999;
    localparam logic [5:0]  SIXTY_LAST = 6'd59;
    localparam logic [4:0]  HOUR_LAST = 5'd23;
    localparam logic [3:0]  MONTH_LAST = 4'd12;
    localparam logic [2:0]  FIELD_LAST = 3'd6;

    localparam int YEAR_SPAN = 74;
    localparam int MONTH_SPAN = 12;
    localparam int HOUR_SPAN = 24;
    localparam int SIXTY_SPAN = 60;
    localparam int MILLI_SPAN = 1000;

    // modular inverse of 25 over 14 bits, for the divisible-by-25 test
    localparam logic [13:0] INV25 = 14'd7209;
    localparam logic [13:0] DIV25_MAX = 14'd655;

    localparam clk_state_t RESET_STATE = '{
        field:   3'd0,
        running: 1'b0,
        milli:   10'd0,
        second:  6'd0,
        minute:  6'd0,
        hour:    5'd0,
        day:     5'd1,
        month:   4'd1,
        year:    14'd2026
    };

endpackage

### src/rtcc_next.sv
// next-state logic of the calendar clock for one request
module rtcc_next #(
    parameter int ADC_BITS = 10
) (
    input  rtcc_pkg::clk_state_t cur,
    input  rtcc_pkg::req_t       req,
    input  logic [9:0]           adc,
    output rtcc_pkg::clk_state_t nxt
);

    localparam int UseW = (ADC_BITS < 10) ? ADC_BITS : 10;
    localparam int ProdW = UseW + 10;

    logic [UseW-1:0]  adc_used;
    logic [13:0]      y_mul;
    logic             div25;
    logic             leap;
    logic [4:0]       mlen;
    logic [ProdW-1:0] p_year, p_month, p_hour, p_sixty, p_milli;
    logic [ProdW-1:0] p_d28, p_d29, p_d30, p_d31, p_day;
    logic [9:0]       s_year, s_month, s_day, s_hour, s_sixty, s_milli;

    assign adc_used = adc[UseW-1:0];

    // gregorian leap test; divisibility by 25 through the modular inverse
    assign y_mul = 14'(cur.year * rtcc_pkg::INV25);
    assign div25 = (y_mul <= rtcc_pkg::DIV25_MAX);
    assign leap  = (cur.year[1:0] == 2'd0) && (!div25 || (cur.year[3:0] == 4'd0));

    always_comb begin
        case (cur.month)
            4'd2:                      mlen = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   mlen = 5'd30;
            default:                   mlen = 5'd31;
        endcase
    end

    // constant-span products, shift-add only
    assign p_year  = ProdW'(adc_used) * ProdW'(rtcc_pkg::YEAR_SPAN);
    assign p_month = ProdW'(adc_used) * ProdW'(rtcc_pkg::MONTH_SPAN);
    assign p_hour  = ProdW'(adc_used) * ProdW'(rtcc_pkg::HOUR_SPAN);
    assign p_sixty = ProdW'(adc_used) * ProdW'(rtcc_pkg::SIXTY_SPAN);
    assign p_milli = ProdW'(adc_used) * ProdW'(rtcc_pkg::MILLI_SPAN);
    assign p_d28   = ProdW'(adc_used) * ProdW'(28);
    assign p_d29   = ProdW'(adc_used) * ProdW'(29);
    assign p_d30   = ProdW'(adc_used) * ProdW'(30);
    assign p_d31   = ProdW'(adc_used) * ProdW'(31);

    always_comb begin
        case (mlen)
            5'd28:   p_day = p_d28;
            5'd29:   p_day = p_d29;
            5'd30:   p_day = p_d30;
            default: p_day = p_d31;
        endcase
    end

    assign s_year  = 10'(p_year >> ADC_BITS);
    assign s_month = 10'(p_month >> ADC_BITS);
    assign s_day   = 10'(p_day >> ADC_BITS);
    assign s_hour  = 10'(p_hour >> ADC_BITS);
    assign s_sixty = 10'(p_sixty >> ADC_BITS);
    assign s_milli = 10'(p_milli >> ADC_BITS);

    always_comb begin
        nxt = cur;
        case (req)
            rtcc_pkg::REQ_TICK: begin
                if (cur.running) begin
                    if (cur.milli < rtcc_pkg::MILLI_LAST) begin
                        nxt.milli = cur.milli + 10'd1;
                    end else begin
                        nxt.milli = '0;
                        if (cur.second < rtcc_pkg::SIXTY_LAST) begin
                            nxt.second = cur.second + 6'd1;
                        end else begin
                            nxt.second = '0;
                            if (cur.minute < rtcc_pkg::SIXTY_LAST) begin
                                nxt.minute = cur.minute + 6'd1;
                            end else begin
                                nxt.minute = '0;
                                if (cur.hour < rtcc_pkg::HOUR_LAST) begin
                                    nxt.hour = cur.hour + 5'd1;
                                end else begin
                                    nxt.hour = '0;
                                    if (cur.day < mlen) begin
                                        nxt.day = cur.day + 5'd1;
                                    end else begin
                                        nxt.day = 5'd1;
                                        if (cur.month < rtcc_pkg::MONTH_LAST) begin
                                            nxt.month = cur.month + 4'd1;
                                        end else begin
                                            nxt.month = 4'd1;
                                            nxt.year = (cur.year >= rtcc_pkg::YEAR_LAST) ?
                                                14'd0 : cur.year + 14'd1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
            end
            rtcc_pkg::REQ_SELECT: begin
                nxt.field = (cur.field >= rtcc_pkg::FIELD_LAST) ? 3'd0 : cur.field + 3'd1;
            end
            rtcc_pkg::REQ_TOGGLE: begin
                nxt.running = !cur.running;
            end
            rtcc_pkg::REQ_SAMPLE: begin
                if (!cur.running) begin
                    case (cur.field)
                        rtcc_pkg::FIELD_YEAR:   nxt.year = 14'(s_year) + rtcc_pkg::YEAR_BASE;
                        rtcc_pkg::FIELD_MONTH:  nxt.month = 4'(s_month) + 4'd1;
                        rtcc_pkg::FIELD_DAY:    nxt.day = 5'(s_day) + 5'd1;
                        rtcc_pkg::FIELD_HOUR:   nxt.hour = 5'(s_hour);
                        rtcc_pkg::FIELD_MINUTE: nxt.minute = 6'(s_sixty);
                        rtcc_pkg::FIELD_SECOND: nxt.second = 6'(s_sixty);
                        rtcc_pkg::FIELD_MILLI:  nxt.milli = s_milli;
                        default:                nxt = cur;
                    endcase
                end
            end
            default: nxt = cur;
        endcase
    end

endmodule

### src/rtcc_out_stage.sv
// result register of the calendar clock with its stream handshake
module rtcc_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  rtcc_pkg::clk_state_t            result,
    output logic                            free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rtcc_pkg::M_DATA_W-1:0]   m_tdata
);

    logic                 valid_reg;
    rtcc_pkg::clk_state_t data_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = rtcc_pkg::M_DATA_W'(data_reg);

endmodule

### src/calendar_clock_with_adc_set.sv
// top level of the millisecond calendar clock with potentiometer setting
//
// Millisecond calendar clock with Gregorian leap years. Each request on the
// s_ stream is one of: a one-millisecond tick (advances the time with carries
// through second, minute, hour, day, month and year while running; the year
// wraps from 9999 to 0), select (moves the edited field 0 year .. 6 milli,
// cyclic), toggle (starts or stops the clock) or sample (while stopped, sets
// the edited field to floor(adc * span / 2^ADC_BITS) + base; the day span is
// the current month length). Every request gives exactly one result on the
// m_ stream: the full time and status after that request. A request passes
// an input register, then the next-state logic into the clock state and the
// result register, so throughput is one request per cycle while the result
// side does not stall; m_tvalid is set when the request moves from the
// input register into the result register. While a result waits
// on m_tready, one more request is taken into the input register.
`include "assert_macros.svh"

module calendar_clock_with_adc_set #(
    parameter int ADC_BITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [9:0] adc_value, rest zero
    input  logic [1:0]                      s_tuser,   // [1:0] req_type
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [13:0] year_out, [17:14] month_out, [22:18] day_out, [27:23] hour_out,
    // [33:28] minute_out, [39:34] second_out, [49:40] milli_out,
    // [50] running, [53:51] edit_field, [55:54] zero
    output logic [rtcc_pkg::M_DATA_W-1:0]   m_tdata
);

    // input register
    logic                 in_valid_reg;
    rtcc_pkg::req_t       in_req_reg;
    logic [9:0]           in_adc_reg;

    // clock state
    rtcc_pkg::clk_state_t state_reg;
    rtcc_pkg::clk_state_t state_next;

    logic                 out_free;
    logic                 advance;
    logic                 s_fire;

    // terms for the checks at the end
    logic                 milli_wrap_tick;
    logic                 month_legal;

    // a buffered request moves on whenever the result register can take it
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg <= rtcc_pkg::req_t'(s_tuser);
            in_adc_reg <= s_tdata[9:0];
        end
    end

    // all the per-request work: tick carries, select, toggle, sample scaling
    rtcc_next #(
        .ADC_BITS(ADC_BITS)
    ) u_next (
        .cur(state_reg),
        .req(in_req_reg),
        .adc(in_adc_reg),
        .nxt(state_next)
    );

    // clock state commits together with the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rtcc_pkg::RESET_STATE;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    rtcc_out_stage u_out (
        .aclk(aclk),
        .aresetn(aresetn),
        .load(advance),
        .result(state_next),
        .free(out_free),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    assign milli_wrap_tick = advance && (in_req_reg == rtcc_pkg::REQ_TICK) &&
                             state_reg.running && (state_reg.milli == rtcc_pkg::MILLI_LAST);
    assign month_legal = (state_reg.month >= 4'd1) &&
                         (state_reg.month <= rtcc_pkg::MONTH_LAST);

    // a buffered request is never dropped while the result side stalls
    `RTCC_ASSERT_NXT(a_hold_request, aclk, aresetn, in_valid_reg && !out_free, in_valid_reg)

    // the clock state only changes when a request is committed
    `RTCC_ASSERT_NXT(a_state_quiet, aclk, aresetn, !advance, $stable(state_reg))

    // month stays within January..December
    `RTCC_ASSERT_IMP(a_month_range, aclk, aresetn, 1'b1, month_legal)

    // a running tick at the last millisecond wraps the milliseconds to zero
    `RTCC_ASSERT_NXT(a_milli_carry, aclk, aresetn, milli_wrap_tick, state_reg.milli == 10'd0)

endmodule

### verif/tb_calendar_clock_with_adc_set.sv
// self-checking testbench for the millisecond calendar clock with potentiometer setting
module tb_calendar_clock_with_adc_set;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADC_BITS = 10;
    localparam int unsigned YEAR_WRAP = 10000;
    localparam int unsigned RANDOM_REQUESTS = 800;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata = '0;    // [9:0] adc_value, [15:10] zero
    logic [1:0]          s_tuser = rtcc_pkg::REQ_TICK;   // [1:0] req_type
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute,
    // [39:34] second, [49:40] milli, [50] running, [53:51] edit field
    logic [rtcc_pkg::M_DATA_W-1:0] m_tdata;

    calendar_clock_with_adc_set #(
        .ADC_BITS(ADC_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // calendar as predicted after the last accepted request
    rtcc_pkg::clk_state_t  cal_now;
    // predicted calendar snapshots still waiting for their result
    rtcc_pkg::clk_state_t  pending_times[$];

    int unsigned errors = 0;
    int unsigned results_checked = 0;
    int unsigned requests_sent = 0;
    int unsigned kind_count[4];
    int unsigned month_carries = 0;
    int unsigned burst_left = 0;

    // receiver stall pattern state
    int unsigned ready_mode = 0;
    int unsigned ready_left = 0;
    int unsigned ready_phase = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------

    function automatic int unsigned days_in_month(int unsigned month, int unsigned year);
        bit leap_year;
        leap_year = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        case (month)
            2: return leap_year ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    // potentiometer reading scaled onto a span, truncated
    function automatic int unsigned pot_scaled(logic [9:0] adc, int unsigned span);
        return (int'(adc) * span) >> ADC_BITS;
    endfunction

    // day carry into month and year, day may sit past the month end after edits
    task automatic roll_day();
        if (cal_now.day >= days_in_month(32'(cal_now.month), 32'(cal_now.year))) begin
            cal_now.day = 5'd1;
            month_carries++;
            if (cal_now.month >= rtcc_pkg::MONTH_LAST) begin
                cal_now.month = 4'd1;
                cal_now.year = 14'((32'(cal_now.year) + 1) % YEAR_WRAP);
            end else begin
                cal_now.month = cal_now.month + 4'd1;
            end
        end else begin
            cal_now.day = cal_now.day + 5'd1;
        end
    endtask

    task automatic tick_millisecond();
        if (cal_now.milli < rtcc_pkg::MILLI_LAST) begin
            cal_now.milli = cal_now.milli + 10'd1;
        end else begin
            cal_now.milli = '0;
            if (cal_now.second < rtcc_pkg::SIXTY_LAST) begin
                cal_now.second = cal_now.second + 6'd1;
            end else begin
                cal_now.second = '0;
                if (cal_now.minute < rtcc_pkg::SIXTY_LAST) begin
                    cal_now.minute = cal_now.minute + 6'd1;
                end else begin
                    cal_now.minute = '0;
                    if (cal_now.hour < rtcc_pkg::HOUR_LAST) begin
                        cal_now.hour = cal_now.hour + 5'd1;
                    end else begin
                        cal_now.hour = '0;
                        roll_day();
                    end
                end
            end
        end
    endtask

    task automatic apply_request(rtcc_pkg::req_t kind, logic [9:0] adc);
        case (kind)
            rtcc_pkg::REQ_TICK: begin
                if (cal_now.running) tick_millisecond();
            end
            rtcc_pkg::REQ_SELECT: begin
                cal_now.field = (cal_now.field >= rtcc_pkg::FIELD_LAST) ? rtcc_pkg::FIELD_YEAR
                                                                        : cal_now.field + 3'd1;
            end
            rtcc_pkg::REQ_TOGGLE: begin
                cal_now.running = ~cal_now.running;
            end
            default: begin
                // samples only land while the clock is stopped
                if (!cal_now.running) begin
                    case (cal_now.field)
                        rtcc_pkg::FIELD_YEAR: cal_now.year = rtcc_pkg::YEAR_BASE +
                                          14'(pot_scaled(adc, rtcc_pkg::YEAR_SPAN));
                        rtcc_pkg::FIELD_MONTH: cal_now.month =
                                          4'(1 + pot_scaled(adc, rtcc_pkg::MONTH_SPAN));
                        rtcc_pkg::FIELD_DAY: cal_now.day = 5'(1 + pot_scaled(adc,
                                          days_in_month(32'(cal_now.month), 32'(cal_now.year))));
                        rtcc_pkg::FIELD_HOUR: cal_now.hour =
                                          5'(pot_scaled(adc, rtcc_pkg::HOUR_SPAN));
                        rtcc_pkg::FIELD_MINUTE: cal_now.minute =
                                          6'(pot_scaled(adc, rtcc_pkg::SIXTY_SPAN));
                        rtcc_pkg::FIELD_SECOND: cal_now.second =
                                          6'(pot_scaled(adc, rtcc_pkg::SIXTY_SPAN));
                        rtcc_pkg::FIELD_MILLI: cal_now.milli =
                                          10'(pot_scaled(adc, rtcc_pkg::MILLI_SPAN));
                        default: ;
                    endcase
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // request driver: bursts of random length with random gaps
    // ------------------------------------------------------------------

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(rtcc_pkg::req_t kind, logic [9:0] adc);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'd0, adc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // request taken at this edge, predict the snapshot it produces
        apply_request(kind, adc);
        pending_times.push_back(cal_now);
        requests_sent++;
        kind_count[kind]++;
        @(negedge aclk);
    endtask

    function automatic logic [9:0] any_adc();
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic go_to_field(rtcc_pkg::field_t target);
        while (cal_now.field != target) send_request(rtcc_pkg::REQ_SELECT, any_adc());
    endtask

    task automatic set_field(rtcc_pkg::field_t target, logic [9:0] adc);
        go_to_field(target);
        send_request(rtcc_pkg::REQ_SAMPLE, adc);
    endtask

    task automatic set_running(bit want_running);
        if (cal_now.running != want_running) send_request(rtcc_pkg::REQ_TOGGLE, any_adc());
    endtask

    // year reading: a leap year, the last settable year, or anything
    function automatic logic [9:0] pick_year_adc();
        int unsigned offset;
        case ($urandom_range(0, 2))
            0: begin
                offset = 2 + 4 * $urandom_range(0, 17);
                return 10'((offset * 1024 + rtcc_pkg::YEAR_SPAN - 1) / rtcc_pkg::YEAR_SPAN);
            end
            1: return 10'd1023;
            default: return any_adc();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checker and receiver stalls
    // ------------------------------------------------------------------

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        rtcc_pkg::clk_state_t got;
        rtcc_pkg::clk_state_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = rtcc_pkg::clk_state_t'(m_tdata[rtcc_pkg::STATE_W-1:0]);
            if (pending_times.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                errors++;
            end else begin
                want = pending_times.pop_front();
                compare_field("year_out", 32'(want.year), 32'(got.year));
                compare_field("month_out", 32'(want.month), 32'(got.month));
                compare_field("day_out", 32'(want.day), 32'(got.day));
                compare_field("hour_out", 32'(want.hour), 32'(got.hour));
                compare_field("minute_out", 32'(want.minute), 32'(got.minute));
                compare_field("second_out", 32'(want.second), 32'(got.second));
                compare_field("milli_out", 32'(want.milli), 32'(got.milli));
                compare_field("running", 32'(want.running), 32'(got.running));
                compare_field("edit_field", 32'(want.field), 32'(got.field));
                results_checked++;
            end
        end
    end

    // receiver: always ready, coin flip, one in three, or mostly stalled
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 200);
        end
        ready_left--;
        ready_phase++;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (ready_phase % 3 == 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // ticks are ignored while stopped, year takes both ends of its range
    task automatic test_stopped_clock();
        send_request(rtcc_pkg::REQ_TICK, any_adc());
        send_request(rtcc_pkg::REQ_SAMPLE, 10'd0);
        send_request(rtcc_pkg::REQ_SAMPLE, 10'd1023);
    endtask

    // full-scale reading on every other field: dec 31 23:59:59.999
    task automatic test_field_maxima();
        repeat (6) begin
            send_request(rtcc_pkg::REQ_SELECT, any_adc());
            send_request(rtcc_pkg::REQ_SAMPLE, 10'd1023);
        end
    endtask

    // start, sample ignored while running, one tick carries into a new year, stop
    task automatic test_year_rollover();
        send_request(rtcc_pkg::REQ_TOGGLE, any_adc());
        send_request(rtcc_pkg::REQ_SAMPLE, 10'd0);
        send_request(rtcc_pkg::REQ_TICK, any_adc());
        send_request(rtcc_pkg::REQ_TOGGLE, any_adc());
    endtask

    // select wraps from milli to year, then february of a century non-leap year
    task automatic test_century_february();
        send_request(rtcc_pkg::REQ_SELECT, any_adc());
        send_request(rtcc_pkg::REQ_SELECT, any_adc());
        send_request(rtcc_pkg::REQ_SAMPLE, 10'd100);
        send_request(rtcc_pkg::REQ_SELECT, any_adc());
        send_request(rtcc_pkg::REQ_SAMPLE, 10'd1023);
    endtask

    // set up the last millisecond of a day and run across midnight
    task automatic run_midnight_case();
        set_running(1'b0);
        set_field(rtcc_pkg::FIELD_YEAR, pick_year_adc());
        case ($urandom_range(0, 2))
            0: set_field(rtcc_pkg::FIELD_MONTH, 10'd1023);
            1: set_field(rtcc_pkg::FIELD_MONTH, 10'd100);
            default: set_field(rtcc_pkg::FIELD_MONTH, any_adc());
        endcase
        set_field(rtcc_pkg::FIELD_DAY, ($urandom_range(0, 2) == 0) ? any_adc() : 10'd1023);
        // editing the month after the day can leave the day past the month end
        if ($urandom_range(0, 2) == 0) set_field(rtcc_pkg::FIELD_MONTH, any_adc());
        set_field(rtcc_pkg::FIELD_HOUR, 10'd1023);
        set_field(rtcc_pkg::FIELD_MINUTE, 10'd1023);
        set_field(rtcc_pkg::FIELD_SECOND, 10'd1023);
        set_field(rtcc_pkg::FIELD_MILLI, ($urandom_range(0, 3) == 0) ? any_adc() : 10'd1023);
        set_running(1'b1);
        repeat ($urandom_range(1, 5)) send_request(rtcc_pkg::REQ_TICK, any_adc());
    endtask

    // random edits, then a run of ticks with a few stray requests mixed in
    task automatic run_edit_case();
        rtcc_pkg::field_t target;
        set_running(1'b0);
        repeat ($urandom_range(1, 4)) begin
            target = rtcc_pkg::field_t'($urandom_range(0, 6));
            set_field(target, ($urandom_range(0, 1) == 0) ? any_adc()
                                                          : 10'($urandom_range(960, 1023)));
        end
        set_running(1'b1);
        repeat ($urandom_range(1, 40)) begin
            case ($urandom_range(0, 19))
                0: send_request(rtcc_pkg::REQ_SAMPLE, any_adc());
                1: send_request(rtcc_pkg::REQ_SELECT, any_adc());
                default: send_request(rtcc_pkg::REQ_TICK, any_adc());
            endcase
        end
        if ($urandom_range(0, 1) == 0) send_request(rtcc_pkg::REQ_TOGGLE, any_adc());
    endtask

    task automatic test_random_traffic();
        int unsigned target_count;
        target_count = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < target_count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_midnight_case();
                4, 5, 6, 7: run_edit_case();
                default: begin
                    // unstructured noise
                    repeat ($urandom_range(1, 10))
                        send_request(rtcc_pkg::req_t'($urandom_range(0, 3)), any_adc());
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        // predictor starts from the reset calendar: 2026-01-01 00:00:00.000, stopped
        cal_now = '0;
        cal_now.year = 14'd2026;
        cal_now.month = 4'd1;
        cal_now.day = 5'd1;
        cal_now.field = rtcc_pkg::FIELD_YEAR;
        foreach (kind_count[i]) kind_count[i] = 0;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_stopped_clock();
        test_field_maxima();
        test_year_rollover();
        test_century_february();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (pending_times.size() != 0) @(posedge aclk);
        // catch any stray result after the last one
        repeat (10) @(posedge aclk);

        $display("tb: %0d requests (%0d ticks, %0d selects, %0d toggles, %0d samples)",
                 requests_sent, kind_count[rtcc_pkg::REQ_TICK],
                 kind_count[rtcc_pkg::REQ_SELECT], kind_count[rtcc_pkg::REQ_TOGGLE],
                 kind_count[rtcc_pkg::REQ_SAMPLE]);
        $display("tb: %0d results checked, %0d day carries into a new month",
                 results_checked, month_carries);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
